// ===== hdl/cmf_pkg.sv =====
package cmf_pkg;

    // Configuration port: register indexes, widths and reset values.
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = IMAGE_WIDTH_W'(640);
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = IMAGE_HEIGHT_W'(480);

    // Widths of the position fields on the result port.
    localparam int COLUMN_W  = 10;
    localparam int ROW_OUT_W = 12;

    // Which of the up to three results of one pixel is being produced.
    typedef enum logic [1:0] {
        RES_ABOVE,
        RES_LAST_ROW,
        RES_FINAL
    } t_res_sel;

    // Border information for the neighbourhood of one pixel transaction.
    typedef struct packed {
        logic has_left;
        logic has_right;
        logic has_up2;
        logic has_left2;
    } t_nbr_flags;

endpackage

// ===== hdl/cmf_line_bank.sv =====
module cmf_line_bank #(
    parameter int DEPTH  = 512,
    parameter int DATA_W = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    // One write port; the reads return the contents from before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports, held while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== hdl/cmf_median5.sv =====
module cmf_median5 #(
    parameter int DATA_W = 8
) (
    input  logic [4:0][DATA_W-1:0] i_values,
    output logic [DATA_W-1:0]      o_median
);

    typedef logic [4:0][DATA_W-1:0] t_vec5;

    // Order one pair of elements, the smaller value to the lower index.
    function automatic t_vec5 cmp_swap(t_vec5 x, int lo, int hi);
        t_vec5 y;
        y = x;
        if (x[lo] > x[hi]) begin
            y[lo] = x[hi];
            y[hi] = x[lo];
        end
        return y;
    endfunction

    t_vec5 w_sorted;

    // Nine-comparator sorting network of depth six; the middle element is the median.
    always_comb begin
        w_sorted = i_values;
        w_sorted = cmp_swap(w_sorted, 0, 1);
        w_sorted = cmp_swap(w_sorted, 3, 4);
        w_sorted = cmp_swap(w_sorted, 2, 4);
        w_sorted = cmp_swap(w_sorted, 2, 3);
        w_sorted = cmp_swap(w_sorted, 1, 4);
        w_sorted = cmp_swap(w_sorted, 0, 3);
        w_sorted = cmp_swap(w_sorted, 0, 2);
        w_sorted = cmp_swap(w_sorted, 1, 3);
        w_sorted = cmp_swap(w_sorted, 1, 2);
    end

    assign o_median = w_sorted[2];

endmodule

// ===== hdl/cross_median_filter.sv =====
// Channel   Direction  Handshake                  Payload
// pixel     in         i_pix_valid / o_pix_stall  i_pixel
// result    out        o_res_valid / i_res_stall  o_res_filtered, o_res_column,
//                                                 o_res_row, o_res_frame_end
// config    in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// One pixel per cycle while results are not stalled, in rows above the last and in
// the first column of the last row; other pixels of the last row give two results
// and the final pixel of the frame three, which hold off the next pixel, since every
// result passes the single median unit and output register one at a time. The first
// result of a pixel transaction passes the working stage and output registers, and
// further results of that pixel follow one per cycle while results are not stalled.
// Synchronous reset clears the position counters, the pipeline and the output.
// A stall on the result side holds the output register and, once the pending
// results of the held pixel cannot drain, raises o_pix_stall in the same cycle.
module cross_median_filter
    import cmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_pix_valid,
    output logic                   o_pix_stall,
    input  logic [PIXEL_BITS-1:0]  i_pixel,
    output logic                   o_res_valid,
    input  logic                   i_res_stall,
    output logic [PIXEL_BITS-1:0]  o_res_filtered,
    output logic [COLUMN_W-1:0]    o_res_column,
    output logic [ROW_OUT_W-1:0]   o_res_row,
    output logic                   o_res_frame_end
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ROW_PW  = ROW_W + 1;
    localparam int EW_W    = $clog2(MAX_WIDTH + 1);
    localparam int EH_W    = $clog2(MAX_HEIGHT + 1);
    localparam int BANK_D  = (MAX_WIDTH + 1) / 2;
    localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

    // Configuration registers
    logic [IMAGE_WIDTH_W-1:0]  r_image_width;
    logic [IMAGE_HEIGHT_W-1:0] r_image_height;
    logic [EW_W-1:0]           w_width_eff;
    logic [EH_W-1:0]           w_height_eff;

    // Position of the next pixel and the two most recent pixels
    logic [COL_W-1:0]      r_col_cnt;
    logic [ROW_W-1:0]      r_row_cnt;
    logic [PIXEL_BITS-1:0] r_recent0;
    logic [PIXEL_BITS-1:0] r_recent1;

    // Position of the pixel being accepted
    logic              w_col_wrap;
    logic [COL_W-1:0]  w_col;
    logic [ROW_PW-1:0] w_row_pre;
    logic [ROW_W-1:0]  w_row;
    logic              w_col_last;
    logic              w_row_last;
    logic [2:0]        w_emit;
    t_nbr_flags        w_flags;
    logic              w_accept;

    // Line store addressing: four banks by row parity and column parity
    logic [BANK_AW-1:0]    w_addr_c;
    logic [BANK_AW-1:0]    w_addr_m;
    logic [BANK_AW-1:0]    w_addr_p;
    logic [PIXEL_BITS-1:0] w_rd0 [4];
    logic [PIXEL_BITS-1:0] w_rd1 [4];

    // Working stage
    logic [2:0]            r_s1_pend;
    logic [2:0]            n_s1_pend;
    logic [PIXEL_BITS-1:0] r_s1_pixel;
    logic [COL_W-1:0]      r_s1_col;
    logic [ROW_W-1:0]      r_s1_row;
    t_nbr_flags            r_s1_flags;
    logic [PIXEL_BITS-1:0] r_s1_recent0;
    logic [PIXEL_BITS-1:0] r_s1_recent1;
    logic [1:0]            w_prv_idx;
    logic [1:0]            w_cur_idx;
    logic [1:0]            w_oth_idx;
    logic [PIXEL_BITS-1:0] w_ce;
    logic [PIXEL_BITS-1:0] w_up;
    logic [PIXEL_BITS-1:0] w_lf;
    logic [PIXEL_BITS-1:0] w_rt;
    logic [2:0]            w_pend_low;
    logic                  w_out_free;
    logic                  w_fire;
    t_res_sel              w_sel;

    logic [4:0][PIXEL_BITS-1:0] w_med_in;
    logic [PIXEL_BITS-1:0]      w_median;
    logic [COLUMN_W-1:0]        w_res_col;
    logic [ROW_OUT_W-1:0]       w_res_row;
    logic                       w_res_fe;

    // Output register
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_filtered;
    logic [COLUMN_W-1:0]   r_out_col;
    logic [ROW_OUT_W-1:0]  r_out_row;
    logic                  r_out_fe;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMAGE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IMAGE_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame geometry clamped into the supported range.
    always_comb begin
        if (r_image_width < IMAGE_WIDTH_W'(2)) begin
            w_width_eff = EW_W'(2);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_width_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_width_eff = EW_W'(r_image_width);
        end
        if (r_image_height < IMAGE_HEIGHT_W'(2)) begin
            w_height_eff = EH_W'(2);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            w_height_eff = EH_W'(MAX_HEIGHT);
        end else begin
            w_height_eff = EH_W'(r_image_height);
        end
    end

    // Position of the incoming pixel; a shrunken geometry moves it to the next row
    // or back to the top of the frame.
    always_comb begin
        w_col_wrap = (32'(r_col_cnt) >= 32'(w_width_eff));
        if (w_col_wrap) begin
            w_col     = '0;
            w_row_pre = ROW_PW'(r_row_cnt) + ROW_PW'(1);
        end else begin
            w_col     = r_col_cnt;
            w_row_pre = ROW_PW'(r_row_cnt);
        end
        if (32'(w_row_pre) >= 32'(w_height_eff)) begin
            w_row = '0;
        end else begin
            w_row = ROW_W'(w_row_pre);
        end
        w_col_last = (32'(w_col) + 32'd1 >= 32'(w_width_eff));
        w_row_last = (32'(w_row) + 32'd1 >= 32'(w_height_eff));
    end

    // Which results this pixel releases, and which neighbours lie inside the frame.
    always_comb begin
        w_emit[0]         = (w_row != '0);
        w_emit[1]         = w_row_last && (w_col != '0);
        w_emit[2]         = w_row_last && w_col_last;
        w_flags.has_left  = (w_col != '0);
        w_flags.has_right = !w_col_last;
        w_flags.has_up2   = (32'(w_row) >= 32'd2);
        w_flags.has_left2 = (32'(w_col) >= 32'd2);
    end

    // Bank addresses for the centre column and its two horizontal neighbours.
    assign w_addr_c = BANK_AW'(32'(w_col) >> 1);
    assign w_addr_m = BANK_AW'((32'(w_col) - 32'd1) >> 1);
    assign w_addr_p = BANK_AW'((32'(w_col) + 32'd1) >> 1);

    // Columns c-1 and c+1 always fall into the bank of the other column parity,
    // so no bank is read at more than two addresses.
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam logic ROW_SEL = 1'(gb >> 1);
        localparam logic COL_SEL = 1'(gb);

        logic               w_we;
        logic [BANK_AW-1:0] w_raddr0;

        assign w_we     = w_accept && (w_row[0] == ROW_SEL) && (w_col[0] == COL_SEL);
        assign w_raddr0 = (w_col[0] == COL_SEL) ? w_addr_c : w_addr_m;

        cmf_line_bank #(
            .DEPTH  (BANK_D),
            .DATA_W (PIXEL_BITS)
        ) u_bank (
            .i_clk    (i_clk),
            .i_we     (w_we),
            .i_waddr  (w_addr_c),
            .i_wdata  (i_pixel),
            .i_re     (w_accept),
            .i_raddr0 (w_raddr0),
            .i_raddr1 (w_addr_p),
            .o_rdata0 (w_rd0[gb]),
            .o_rdata1 (w_rd1[gb])
        );
    end

    // Position counters and recent pixels advance on each pixel transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_recent0 <= '0;
            r_recent1 <= '0;
        end else if (w_accept) begin
            r_recent0 <= i_pixel;
            r_recent1 <= r_recent0;
            if (w_col_last) begin
                r_col_cnt <= '0;
                r_row_cnt <= w_row_last ? '0 : w_row + ROW_W'(1);
            end else begin
                r_col_cnt <= w_col + COL_W'(1);
                r_row_cnt <= w_row;
            end
        end
    end

    // Results leave one at a time, lowest pending first, whenever the output
    // register is empty or being emptied.
    always_comb begin
        w_out_free = !r_out_valid || !i_res_stall;
        w_fire     = (r_s1_pend != '0) && w_out_free;
        w_pend_low = r_s1_pend & (~r_s1_pend + 3'd1);
        n_s1_pend  = w_fire ? (r_s1_pend & ~w_pend_low) : r_s1_pend;
        if (r_s1_pend[0]) begin
            w_sel = RES_ABOVE;
        end else if (r_s1_pend[1]) begin
            w_sel = RES_LAST_ROW;
        end else begin
            w_sel = RES_FINAL;
        end
    end

    assign o_pix_stall = (n_s1_pend != '0);
    assign w_accept    = i_pix_valid && !o_pix_stall;

    // Working stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pend <= '0;
        end else if (w_accept) begin
            r_s1_pend <= w_emit;
        end else begin
            r_s1_pend <= n_s1_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pixel   <= i_pixel;
            r_s1_col     <= w_col;
            r_s1_row     <= w_row;
            r_s1_flags   <= w_flags;
            r_s1_recent0 <= r_recent0;
            r_s1_recent1 <= r_recent1;
        end
    end

    // Pick the line store words out of the four banks.
    always_comb begin
        w_prv_idx = {~r_s1_row[0], r_s1_col[0]};
        w_cur_idx = {r_s1_row[0], r_s1_col[0]};
        w_oth_idx = {~r_s1_row[0], ~r_s1_col[0]};
        w_ce      = w_rd0[w_prv_idx];
        w_up      = w_rd0[w_cur_idx];
        w_lf      = w_rd0[w_oth_idx];
        w_rt      = w_rd1[w_oth_idx];
    end

    // Operands and position of the result now being produced.
    always_comb begin
        unique case (w_sel)
            RES_ABOVE: begin
                w_med_in[0] = w_ce;
                w_med_in[1] = r_s1_flags.has_up2   ? w_up : w_ce;
                w_med_in[2] = r_s1_pixel;
                w_med_in[3] = r_s1_flags.has_left  ? w_lf : w_ce;
                w_med_in[4] = r_s1_flags.has_right ? w_rt : w_ce;
                w_res_col   = COLUMN_W'(r_s1_col);
                w_res_row   = ROW_OUT_W'(r_s1_row - ROW_W'(1));
                w_res_fe    = 1'b0;
            end
            RES_LAST_ROW: begin
                w_med_in[0] = r_s1_recent0;
                w_med_in[1] = w_lf;
                w_med_in[2] = r_s1_recent0;
                w_med_in[3] = r_s1_flags.has_left2 ? r_s1_recent1 : r_s1_recent0;
                w_med_in[4] = r_s1_pixel;
                w_res_col   = COLUMN_W'(r_s1_col - COL_W'(1));
                w_res_row   = ROW_OUT_W'(r_s1_row);
                w_res_fe    = 1'b0;
            end
            RES_FINAL: begin
                w_med_in[0] = r_s1_pixel;
                w_med_in[1] = w_ce;
                w_med_in[2] = r_s1_pixel;
                w_med_in[3] = r_s1_recent0;
                w_med_in[4] = r_s1_pixel;
                w_res_col   = COLUMN_W'(r_s1_col);
                w_res_row   = ROW_OUT_W'(r_s1_row);
                w_res_fe    = 1'b1;
            end
            default: begin
                w_med_in  = '0;
                w_res_col = '0;
                w_res_row = '0;
                w_res_fe  = 1'b0;
            end
        endcase
    end

    cmf_median5 #(
        .DATA_W (PIXEL_BITS)
    ) u_median (
        .i_values (w_med_in),
        .o_median (w_median)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_filtered <= w_median;
            r_out_col      <= w_res_col;
            r_out_row      <= w_res_row;
            r_out_fe       <= w_res_fe;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_res_filtered  = r_out_filtered;
    assign o_res_column    = r_out_col;
    assign o_res_row       = r_out_row;
    assign o_res_frame_end = r_out_fe;

endmodule

// ===== hdl/cmf_checker.sv =====
module cmf_checker
    import cmf_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_pix_stall,
    input logic                  i_res_valid,
    input logic                  i_res_stall,
    input logic [PIXEL_BITS-1:0] i_res_filtered,
    input logic [COLUMN_W-1:0]   i_res_column,
    input logic [ROW_OUT_W-1:0]  i_res_row,
    input logic                  i_res_frame_end
);

    // After reset there is nothing to deliver and pixels are taken at once.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && !i_pix_stall)
        else $error("block not idle after reset");

    // Pixels are held back only while results are waiting to drain.
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_stall |=> i_res_valid)
        else $error("pixel stall without a pending result");

    // A stalled result keeps its whole payload.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_stall |=>
            i_res_valid && $stable(i_res_filtered) && $stable(i_res_column) &&
            $stable(i_res_row) && $stable(i_res_frame_end))
        else $error("stalled result changed");

    // The end of one frame cannot be followed directly by the end of another.
    a_frame_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_stall && i_res_frame_end |=>
            !(i_res_valid && i_res_frame_end))
        else $error("two frame ends in successive cycles");

endmodule

bind cross_median_filter cmf_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_cmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pix_stall     (o_pix_stall),
    .i_res_valid     (o_res_valid),
    .i_res_stall     (i_res_stall),
    .i_res_filtered  (o_res_filtered),
    .i_res_column    (o_res_column),
    .i_res_row       (o_res_row),
    .i_res_frame_end (o_res_frame_end)
);
